// ===== rtl/imu_dead_reckoning_integrator_unit_macros.svh =====
// Assertion macros for the IMU dead-reckoning integrator.
// Included by the top-level RTL file, which carries the concurrent assertions; no dependencies.
`ifndef IMU_DEAD_RECKONING_INTEGRATOR_UNIT_MACROS_SVH
`define IMU_DEAD_RECKONING_INTEGRATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IDR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant, disabled during reset.
`define IDR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== rtl/idr_pkg.sv =====
// Package for the IMU dead-reckoning integrator: payload structs, register
// indexes, reset values and saturation helpers. No dependencies.
package idr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAV_ON     = 3'd0,
    CFG_GRAV_ORIENT = 3'd1,
    CFG_GRAV_LEVEL  = 3'd2,
    CFG_SMOOTH_WT   = 3'd3,
    CFG_DEADBAND    = 3'd4,
    CFG_DAMPING     = 3'd5,
    CFG_MAX_STEP    = 3'd6
  } cfg_index_e;

  // Register reset values (Q16.16 scaling)
  localparam logic        GRAV_ON_RST     = 1'b1;
  localparam logic        GRAV_ORIENT_RST = 1'b0;
  localparam logic [20:0] GRAV_LEVEL_RST  = 21'd642908;
  localparam logic [16:0] SMOOTH_WT_RST   = 17'd13107;
  localparam logic [20:0] DEADBAND_RST    = 21'd1311;
  localparam logic [20:0] DAMPING_RST     = 21'd1311;
  localparam logic [19:0] MAX_STEP_RST    = 20'd13107;

  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam int unsigned WEIGHT_SHIFT = 16;
  localparam int unsigned TIME_SHIFT   = 16;
  localparam int unsigned QUAT_SHIFT   = 28;
  // damping*dt >> 16 stays below 2^25
  localparam int unsigned DAMP_W       = 26;

  typedef struct packed {
    logic        [31:0] sample_time;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } sample_t;

  typedef struct packed {
    logic        [31:0] out_time;
    logic signed [31:0] smoothed_x;
    logic signed [31:0] smoothed_y;
    logic signed [31:0] smoothed_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_write_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh0000_7fff_ffff_ffff) begin
      return 48'sh7fff_ffff_ffff;
    end else if (v < -64'sh0000_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end else begin
      return v[47:0];
    end
  endfunction

endpackage

// ===== rtl/idr_stream_if.sv =====
// Valid/ready stream interface used for the sample, result and config channels.
// Payload type is a parameter; no package dependency.
interface idr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/imu_dead_reckoning_integrator_unit.sv =====
// IMU dead-reckoning integrator, top level: sequencer around one shared multiplier.
// Depends on idr_pkg, idr_stream_if and imu_dead_reckoning_integrator_unit_macros.svh.
//
//   channel   | modport | payload      | transaction when
//   ----------+---------+--------------+--------------------------
//   sample_i  | sink    | sample_t     | valid & ready
//   result_o  | source  | result_t     | valid & ready
//   cfg_i     | sink    | cfg_write_t  | valid & ready (ready tied high)
//
// A sample that yields a result is stepped through by the micro-op sequencer on the
// single 38x23 multiplier (B grows past 23 bits only when FRAC_BITS exceeds 21), one
// product per cycle, with extra steps when gravity is rotated by the quaternion; the
// next sample is taken only once the result has been copied to the output register.
// The first sample and a non-positive time step finish in the check state with no
// result.
// Reset asynchronously returns all registers but prod_q to their reset values, state stores and output valid included.
// A stalled result sits in the output register while the next sample is taken;
// only the final copy step waits for the output register to free up.
`include "imu_dead_reckoning_integrator_unit_macros.svh"

module imu_dead_reckoning_integrator_unit
  import idr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  idr_stream_if.sink   sample_i,
  idr_stream_if.source result_o,
  idr_stream_if.sink   cfg_i
);

  // Multiplier operand widths: A holds up to v1 (37 bits signed), B holds the
  // unsigned coefficients (2g, k, dt, weights) plus a sign bit.
  localparam int unsigned MA    = 38;
  localparam int unsigned MB    = ((FRAC_BITS + 2) > 23) ? (FRAC_BITS + 2) : 23;
  localparam int unsigned PW    = MA + MB;
  localparam int unsigned ACC_W = 52;
  localparam int unsigned GW    = 27;
  localparam int unsigned KW    = FRAC_BITS + 1;
  localparam int unsigned KDW   = ((FRAC_BITS + 2) > (DAMP_W + 1)) ?
                                  (FRAC_BITS + 2) : (DAMP_W + 1);
  localparam logic [KW-1:0]         K_ONE  = KW'(1) << FRAC_BITS;
  localparam logic signed [KDW-1:0] KD_ONE = KDW'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_CALC  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  // Micro-ops: each names what it multiplies and what it does with the
  // product of the op before it.
  typedef enum logic [4:0] {
    G_XZ   = 5'd0,  G_WY  = 5'd1,  G_YZ   = 5'd2,  G_GX   = 5'd3,
    G_WX   = 5'd4,  G_XX  = 5'd5,  G_GY   = 5'd6,  G_YY   = 5'd7,
    G_SQ   = 5'd8,  G_GZ  = 5'd9,  G_TAKE = 5'd10, D_MUL  = 5'd11,
    D_K    = 5'd12, A_NEW = 5'd13, A_OLD  = 5'd14, A_SUM  = 5'd15,
    A_SAT  = 5'd16, A_DEAD = 5'd17, A_VMUL = 5'd18, A_V1  = 5'd19,
    A_KMUL = 5'd20, A_VSAT = 5'd21, A_PMUL = 5'd22, A_POS = 5'd23
  } step_e;

  state_e state_q;
  step_e  step_q;
  logic [1:0] axis_q;

  // configuration
  logic        grav_on_q;
  logic        grav_orient_q;
  logic [20:0] grav_level_q;
  logic [16:0] wt_q;
  logic [20:0] deadband_q;
  logic [20:0] damping_q;
  logic [19:0] max_step_q;

  // architectural state
  logic               time_seen_q;
  logic        [31:0] prev_time_q;
  logic signed [31:0] mem_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [47:0] pos_q [3];

  // per-sample working registers
  sample_t              item_q;
  logic        [19:0]   dt_q;
  logic        [KW-1:0] k_q;
  logic signed [GW-1:0] grav_q [3];
  logic signed [31:0]   sm_res_q [3];
  logic signed [ACC_W-1:0] acc_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] prod_d;

  result_t out_q;
  logic    out_valid_q;

  // datapath helpers
  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic signed [MA-1:0]  acc_a;
  logic signed [MA-1:0]  axis_a;
  logic signed [MA-1:0]  gz_arg;
  logic signed [31:0]    accel_cur;
  logic signed [31:0]    mem_cur;
  logic        [32:0]    mag;
  logic        [16:0]    wt_new;
  logic        [16:0]    wt_old;
  logic        [31:0]    t_diff;
  logic                  step_le0;
  logic        [19:0]    dt_clamp;
  logic [DAMP_W-1:0]     damp;
  logic signed [KDW-1:0] kd;

  assign sample_i.ready = (state_q == S_IDLE);
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;
  assign cfg_i.ready    = 1'b1;

  // time step: wraps mod 2^32, read as signed
  assign t_diff   = item_q.sample_time - prev_time_q;
  assign step_le0 = t_diff[31] || (t_diff == 32'd0);
  assign dt_clamp = (t_diff > 32'(max_step_q)) ? max_step_q : t_diff[19:0];

  assign damp = prod_q[TIME_SHIFT +: DAMP_W];
  assign kd   = KD_ONE - $signed({1'b0, damp});

  always_comb begin
    unique case (axis_q)
      2'd0:    accel_cur = item_q.accel_x;
      2'd1:    accel_cur = item_q.accel_y;
      default: accel_cur = item_q.accel_z;
    endcase
  end

  always_comb begin
    mem_cur = mem_q[axis_q];
    mag     = mem_cur[31] ? (33'd0 - 33'(mem_cur)) : 33'(mem_cur);
    acc_a   = acc_q[MA-1:0];
    axis_a  = MA'(accel_cur) - MA'(grav_q[axis_q]);
    // 2^28 - 2*(qx^2 + qy^2)
    gz_arg  = (MA'(1) << QUAT_SHIFT) - (acc_a <<< 1);
    wt_new  = (wt_q > WEIGHT_ONE) ? WEIGHT_ONE : wt_q;
    wt_old  = WEIGHT_ONE - wt_new;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_CALC) begin
      unique case (step_q)
        G_XZ: begin mul_a = MA'(item_q.quat_x); mul_b = MB'(item_q.quat_z); end
        G_WY: begin mul_a = MA'(item_q.quat_w); mul_b = MB'(item_q.quat_y); end
        G_YZ: begin mul_a = MA'(item_q.quat_y); mul_b = MB'(item_q.quat_z); end
        G_GX: begin mul_a = acc_a;              mul_b = MB'({grav_level_q, 1'b0}); end
        G_WX: begin mul_a = MA'(item_q.quat_w); mul_b = MB'(item_q.quat_x); end
        G_XX: begin mul_a = MA'(item_q.quat_x); mul_b = MB'(item_q.quat_x); end
        G_GY: begin mul_a = acc_a;              mul_b = MB'({grav_level_q, 1'b0}); end
        G_YY: begin mul_a = MA'(item_q.quat_y); mul_b = MB'(item_q.quat_y); end
        G_GZ: begin mul_a = gz_arg;             mul_b = MB'(grav_level_q); end
        D_MUL: begin mul_a = MA'(damping_q);    mul_b = MB'(dt_q); end
        A_NEW: begin mul_a = axis_a;            mul_b = MB'(wt_new); end
        A_OLD: begin mul_a = MA'(mem_cur);      mul_b = MB'(wt_old); end
        A_VMUL: begin mul_a = MA'(sm_res_q[axis_q]); mul_b = MB'(dt_q); end
        A_KMUL: begin mul_a = acc_a;            mul_b = MB'(k_q); end
        A_PMUL: begin mul_a = MA'(vel_q[axis_q]); mul_b = MB'(dt_q); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= G_XZ;
      axis_q        <= '0;
      grav_on_q     <= GRAV_ON_RST;
      grav_orient_q <= GRAV_ORIENT_RST;
      grav_level_q  <= GRAV_LEVEL_RST;
      wt_q          <= SMOOTH_WT_RST;
      deadband_q    <= DEADBAND_RST;
      damping_q     <= DAMPING_RST;
      max_step_q    <= MAX_STEP_RST;
      time_seen_q   <= 1'b0;
      prev_time_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        mem_q[i]    <= '0;
        vel_q[i]    <= '0;
        pos_q[i]    <= '0;
        grav_q[i]   <= '0;
        sm_res_q[i] <= '0;
      end
      item_q      <= '0;
      dt_q        <= '0;
      k_q         <= '0;
      acc_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // config writes must land only while idle; the block does not enforce this, no interlock here
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          CFG_GRAV_ON:     grav_on_q     <= cfg_i.data.wdata[0];
          CFG_GRAV_ORIENT: grav_orient_q <= cfg_i.data.wdata[0];
          CFG_GRAV_LEVEL:  grav_level_q  <= cfg_i.data.wdata[20:0];
          CFG_SMOOTH_WT:   wt_q          <= cfg_i.data.wdata[16:0];
          CFG_DEADBAND:    deadband_q    <= cfg_i.data.wdata[20:0];
          CFG_DAMPING:     damping_q     <= cfg_i.data.wdata[20:0];
          CFG_MAX_STEP:    max_step_q    <= cfg_i.data.wdata[19:0];
          default: ;
        endcase
      end

      // the copy step owns out_valid_q in its own state
      if (out_valid_q && result_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (sample_i.valid) begin
            item_q  <= sample_i.data;
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          prev_time_q <= item_q.sample_time;
          time_seen_q <= 1'b1;
          // first sample or non-positive step: time only, no result
          if (!time_seen_q || step_le0) begin
            state_q <= S_IDLE;
          end else begin
            dt_q      <= dt_clamp;
            axis_q    <= '0;
            grav_q[0] <= '0;
            grav_q[1] <= '0;
            grav_q[2] <= grav_on_q ? GW'(grav_level_q) : '0;
            step_q    <= (grav_on_q && grav_orient_q) ? G_XZ : D_MUL;
            state_q   <= S_CALC;
          end
        end

        S_CALC: begin
          unique case (step_q)
            // gravity vector from the quaternion
            G_XZ: step_q <= G_WY;
            G_WY: begin acc_q <= ACC_W'(prod_q); step_q <= G_YZ; end
            G_YZ: begin acc_q <= acc_q - ACC_W'(prod_q); step_q <= G_GX; end
            G_GX: begin acc_q <= ACC_W'(prod_q); step_q <= G_WX; end
            G_WX: begin grav_q[0] <= prod_q[QUAT_SHIFT +: GW]; step_q <= G_XX; end
            G_XX: begin acc_q <= acc_q + ACC_W'(prod_q); step_q <= G_GY; end
            G_GY: begin acc_q <= ACC_W'(prod_q); step_q <= G_YY; end
            G_YY: begin grav_q[1] <= prod_q[QUAT_SHIFT +: GW]; step_q <= G_SQ; end
            G_SQ: begin acc_q <= acc_q + ACC_W'(prod_q); step_q <= G_GZ; end
            G_GZ: step_q <= G_TAKE;
            G_TAKE: begin grav_q[2] <= prod_q[QUAT_SHIFT +: GW]; step_q <= D_MUL; end
            // damping factor, clamped at zero
            D_MUL: step_q <= D_K;
            D_K: begin
              k_q    <= kd[KDW-1] ? '0 : kd[KW-1:0];
              step_q <= A_NEW;
            end
            // per-axis smoother, deadband, velocity, position
            A_NEW: step_q <= A_OLD;
            A_OLD: begin acc_q <= ACC_W'(prod_q); step_q <= A_SUM; end
            A_SUM: begin acc_q <= acc_q + ACC_W'(prod_q); step_q <= A_SAT; end
            A_SAT: begin
              mem_q[axis_q] <= sat32(64'(acc_q >>> WEIGHT_SHIFT));
              step_q        <= A_DEAD;
            end
            A_DEAD: begin
              sm_res_q[axis_q] <= (mag < 33'(deadband_q)) ? '0 : mem_cur;
              step_q           <= A_VMUL;
            end
            A_VMUL: step_q <= A_V1;
            A_V1: begin
              acc_q  <= ACC_W'(vel_q[axis_q]) + ACC_W'(prod_q >>> TIME_SHIFT);
              step_q <= A_KMUL;
            end
            A_KMUL: step_q <= A_VSAT;
            A_VSAT: begin
              vel_q[axis_q] <= sat32(64'(prod_q >>> FRAC_BITS));
              step_q        <= A_PMUL;
            end
            A_PMUL: step_q <= A_POS;
            A_POS: begin
              pos_q[axis_q] <= sat48(64'(pos_q[axis_q]) + 64'(prod_q >>> TIME_SHIFT));
              step_q        <= A_NEW;
              if (axis_q == 2'd2) begin
                state_q <= S_OUT;
              end else begin
                axis_q <= axis_q + 2'd1;
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end

        S_OUT: begin
          if (!out_valid_q || result_o.ready) begin
            out_q.out_time   <= item_q.sample_time;
            out_q.smoothed_x <= sm_res_q[0];
            out_q.smoothed_y <= sm_res_q[1];
            out_q.smoothed_z <= sm_res_q[2];
            out_q.vel_x      <= vel_q[0];
            out_q.vel_y      <= vel_q[1];
            out_q.vel_z      <= vel_q[2];
            out_q.pos_x      <= pos_q[0];
            out_q.pos_y      <= pos_q[1];
            out_q.pos_z      <= pos_q[2];
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  `IDR_ASSERT_NEXT(a_check_stores_time, clk_i, rst_ni, state_q == S_CHECK,
    time_seen_q && (prev_time_q == $past(item_q.sample_time)), "time not stored")
  `IDR_ASSERT_ALWAYS(a_k_bounded, clk_i, rst_ni, k_q <= K_ONE, "damping factor above one")
  `IDR_ASSERT_IMPLIES(a_rose_from_out, clk_i, rst_ni, $rose(out_valid_q),
    $past(state_q == S_OUT), "result valid without copy step")
  `IDR_ASSERT_NEXT(a_out_waits, clk_i, rst_ni,
    (state_q == S_OUT) && out_valid_q && !result_o.ready,
    state_q == S_OUT, "pending result overwritten")
  `IDR_ASSERT_ALWAYS(a_axis_range, clk_i, rst_ni, axis_q != 2'd3, "axis counter out of range")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for imu_dead_reckoning_integrator_unit: directed and random IMU samples
// checked against an in-bench dead-reckoning predictor. Depends on idr_pkg and idr_stream_if.
module tb;
  import idr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 60;       // covers the rotated-gravity path
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam longint      S32_MAX       = 64'sd2147483647;
  localparam longint      S32_MIN       = -64'sd2147483648;
  localparam longint      S48_MAX       = 64'sh0000_7fff_ffff_ffff;
  localparam longint      S48_MIN       = -64'sh0000_8000_0000_0000;

  logic clk = 1'b0;
  logic rst_ni;

  idr_stream_if #(.T(sample_t))    sample_if ();
  idr_stream_if #(.T(result_t))    result_if ();
  idr_stream_if #(.T(cfg_write_t)) cfg_if ();

  imu_dead_reckoning_integrator_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor copy of the register file and the integrator state
  // ---------------------------------------------------------------------------
  bit          grav_on;
  bit          grav_orient;
  logic [20:0] grav_level;
  logic [16:0] smooth_wt;
  logic [20:0] deadband;
  logic [20:0] damping;
  logic [19:0] max_step;

  bit          stamp_seen;
  logic [31:0] last_stamp;
  longint      smooth_mem[3];
  longint      vel_state[3];
  longint      pos_state[3];

  result_t     pending_results[$];

  // bookkeeping
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned samples_sent;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned setting_phases;

  // stimulus controls
  bit          sender_gaps_on;
  bit          recv_gaps_on;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned stall_left;
  logic [31:0] stim_stamp;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One sample through the integrator. Returns 1 when the sample yields a result.
  function automatic bit advance_dead_reckoning(input sample_t s, output result_t r);
    logic signed [31:0] diff;
    longint step, g, wt, damp, keep, a, sm, mag, v1, v2;
    longint qw, qx, qy, qz;
    longint acc[3];
    longint gv[3];
    longint sm_out[3];
    r = '0;
    if (!stamp_seen) begin
      stamp_seen = 1'b1;
      last_stamp = s.sample_time;
      return 1'b0;
    end
    diff = s.sample_time - last_stamp;
    step = diff;
    // equal stamp, or a step that wraps past 2^31: just resync the time base
    if (step <= 0) begin
      last_stamp = s.sample_time;
      return 1'b0;
    end
    if (step > longint'(max_step)) step = longint'(max_step);

    acc[0] = s.accel_x;
    acc[1] = s.accel_y;
    acc[2] = s.accel_z;
    for (int i = 0; i < 3; i++) gv[i] = 0;
    g = longint'(grav_level);
    if (grav_on) begin
      if (grav_orient) begin
        // quaternion used as given, no normalization; products are Q4.28
        qw = s.quat_w;
        qx = s.quat_x;
        qy = s.quat_y;
        qz = s.quat_z;
        gv[0] = (2 * g * (qx * qz - qw * qy)) >>> 28;
        gv[1] = (2 * g * (qy * qz + qw * qx)) >>> 28;
        gv[2] = (g * ((64'sd1 <<< 28) - 2 * (qx * qx + qy * qy))) >>> 28;
      end else begin
        gv[2] = g;
      end
    end

    wt = longint'(smooth_wt);
    if (wt > 65536) wt = 65536;
    damp = (longint'(damping) * step) >>> 16;
    keep = 65536 - damp;
    if (keep < 0) keep = 0;

    for (int i = 0; i < 3; i++) begin
      a   = acc[i] - gv[i];
      sm  = clamp((wt * a + (65536 - wt) * smooth_mem[i]) >>> 16, S32_MIN, S32_MAX);
      smooth_mem[i] = sm;
      mag = (sm < 0) ? -sm : sm;
      if (mag < longint'(deadband)) sm = 0;
      sm_out[i] = sm;
      v1 = vel_state[i] + ((sm * step) >>> 16);
      v2 = clamp((v1 * keep) >>> 16, S32_MIN, S32_MAX);
      vel_state[i] = v2;
      pos_state[i] = clamp(pos_state[i] + ((v2 * step) >>> 16), S48_MIN, S48_MAX);
    end
    last_stamp = s.sample_time;

    r.out_time   = s.sample_time;
    r.smoothed_x = sm_out[0][31:0];
    r.smoothed_y = sm_out[1][31:0];
    r.smoothed_z = sm_out[2][31:0];
    r.vel_x      = vel_state[0][31:0];
    r.vel_y      = vel_state[1][31:0];
    r.vel_z      = vel_state[2][31:0];
    r.pos_x      = pos_state[0][47:0];
    r.pos_y      = pos_state[1][47:0];
    r.pos_z      = pos_state[2][47:0];
    return 1'b1;
  endfunction

  task automatic reset_predictor();
    grav_on     = GRAV_ON_RST;
    grav_orient = GRAV_ORIENT_RST;
    grav_level  = GRAV_LEVEL_RST;
    smooth_wt   = SMOOTH_WT_RST;
    deadband    = DEADBAND_RST;
    damping     = DAMPING_RST;
    max_step    = MAX_STEP_RST;
    stamp_seen  = 1'b0;
    last_stamp  = '0;
    for (int i = 0; i < 3; i++) begin
      smooth_mem[i] = 0;
      vel_state[i]  = 0;
      pos_state[i]  = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Failure reporting and result checking
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got)
      note_failure($sformatf("result %0d %s: expected %0h, got %0h",
                             results_checked, name, want, got));
  endfunction

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result, out_time %0h", got.out_time));
      end else begin
        want = pending_results.pop_front();
        check_field("out_time",   want.out_time,   got.out_time);
        check_field("smoothed_x", want.smoothed_x, got.smoothed_x);
        check_field("smoothed_y", want.smoothed_y, got.smoothed_y);
        check_field("smoothed_z", want.smoothed_z, got.smoothed_z);
        check_field("vel_x",      want.vel_x,      got.vel_x);
        check_field("vel_y",      want.vel_y,      got.vel_y);
        check_field("vel_z",      want.vel_z,      got.vel_z);
        check_field("pos_x",      want.pos_x,      got.pos_x);
        check_field("pos_y",      want.pos_y,      got.pos_y);
        check_field("pos_z",      want.pos_z,      got.pos_z);
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Idle gaps, receiver side, watchdog
  // ---------------------------------------------------------------------------
  // Mostly zero or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: a requested hold-off wins, otherwise random stalls when enabled.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      result_if.ready = 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      result_if.ready = 1'b0;
      stall_left--;
    end else begin
      result_if.ready = 1'b1;
      if (recv_gaps_on) stall_left = pick_gap();
    end
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers: all called at a falling edge and return at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    result_t     r;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      sample_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_if.data  = s;
    sample_if.valid = 1'b1;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    // transaction taken at this edge
    if (advance_dead_reckoning(s, r)) pending_results.push_back(r);
    samples_sent++;
    @(negedge clk);
    sample_if.valid = 1'b0;
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [20:0] value);
    cfg_if.data.index = idx;
    cfg_if.data.wdata = value;
    cfg_if.valid      = 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_GRAV_ON:     grav_on     = value[0];
      CFG_GRAV_ORIENT: grav_orient = value[0];
      CFG_GRAV_LEVEL:  grav_level  = value;
      CFG_SMOOTH_WT:   smooth_wt   = value[16:0];
      CFG_DEADBAND:    deadband    = value;
      CFG_DAMPING:     damping     = value;
      CFG_MAX_STEP:    max_step    = value[19:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Block is idle once every result is back and a no-result sample had time to retire.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_settings(input bit on, input bit orient, input logic [20:0] level,
                                  input logic [20:0] wt, input logic [20:0] db,
                                  input logic [20:0] damp, input logic [20:0] step);
    wait_idle();
    write_register(CFG_GRAV_ON, {20'd0, on});
    write_register(CFG_GRAV_ORIENT, {20'd0, orient});
    write_register(CFG_GRAV_LEVEL, level);
    write_register(CFG_SMOOTH_WT, wt);
    write_register(CFG_DEADBAND, db);
    write_register(CFG_DAMPING, damp);
    write_register(CFG_MAX_STEP, step);
    setting_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generators
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_accel(input bit is_z);
    int unsigned r;
    int          base;
    r    = $urandom_range(0, 99);
    base = is_z ? 642908 : 0;
    if (r < 40) return base + int'($urandom_range(0, 524288)) - 262144;
    if (r < 60) return int'($urandom_range(0, 2097152)) - 1048576;
    if (r < 80) return $urandom;
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
  endfunction

  function automatic logic signed [15:0] rand_quat_part();
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic sample_t build_sample(input logic [31:0] stamp);
    sample_t s;
    int unsigned r;
    s.sample_time = stamp;
    s.accel_x     = rand_accel(1'b0);
    s.accel_y     = rand_accel(1'b0);
    s.accel_z     = rand_accel(1'b1);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      // a few unit-length orientations
      case ($urandom_range(0, 3))
        0:       {s.quat_w, s.quat_x, s.quat_y, s.quat_z} = {16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        1:       {s.quat_w, s.quat_x, s.quat_y, s.quat_z} = {16'sd11585, 16'sd11585, 16'sd0, 16'sd0};
        2:       {s.quat_w, s.quat_x, s.quat_y, s.quat_z} = {16'sd11585, 16'sd0, 16'sd11585, 16'sd0};
        default: {s.quat_w, s.quat_x, s.quat_y, s.quat_z} = {4{16'sd8192}};
      endcase
    end else if (r < 85) begin
      s.quat_w = rand_quat_part();
      s.quat_x = rand_quat_part();
      s.quat_y = rand_quat_part();
      s.quat_z = rand_quat_part();
    end else begin
      s.quat_w = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      s.quat_x = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      s.quat_y = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      s.quat_z = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    end
    return s;
  endfunction

  // Mostly forward steps; some clamped, some equal, backward or wrapping past 2^31.
  function automatic logic [31:0] rand_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 62) return $urandom_range(1, (max_step == 0) ? 1000 : max_step);
    if (r < 75) return $urandom_range(1, 64);
    if (r < 85) return max_step + $urandom_range(1, 2000000);
    if (r < 90) return 32'd0;
    if (r < 95) return -$urandom_range(1, 100000);
    return 32'h8000_0000 + $urandom_range(0, 32'h7fff_ffff);
  endfunction

  // Extremes and the usual value show up often; the rest spreads over the range.
  function automatic logic [20:0] pick_value(input int unsigned top, input int unsigned usual);
    case ($urandom_range(0, 7))
      0:       return 21'd0;
      1:       return 21'(top);
      2, 3:    return 21'(usual);
      4, 5:    return 21'($urandom_range(0, (usual * 2 > top) ? top : usual * 2));
      default: return 21'($urandom_range(0, top));
    endcase
  endfunction

  task automatic send_stepped(input logic [31:0] step, input logic signed [31:0] ax,
                              input logic signed [31:0] ay, input logic signed [31:0] az);
    sample_t s;
    stim_stamp = stim_stamp + step;
    s = build_sample(stim_stamp);
    s.accel_x = ax;
    s.accel_y = ay;
    s.accel_z = az;
    send_sample(s);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: first sample, equal stamp, wrap across 2^32, clamped step,
  // step of exactly 2^31, largest positive step, minimal step, backward step.
  task automatic test_directed_basics();
    sender_gaps_on = 1'b1;
    recv_gaps_on   = 1'b1;
    stim_stamp     = 32'hffff_f000;
    send_stepped(32'd0, 32'sd0, 32'sd0, 32'sd0);               // first sample: time only
    send_stepped(32'd0, 32'sd5, 32'sd5, 32'sd5);               // equal stamp
    send_stepped(32'h2000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd642908);
    send_stepped(32'd50000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd0);
    send_stepped(32'h8000_0000, 32'sd100, 32'sd100, 32'sd100); // dt = -2^31
    send_stepped(32'h7fff_ffff, -32'sd1, 32'sd1, 32'sd1311);
    send_stepped(32'd1, 32'sd0, 32'sd0, 32'sd0);
    send_stepped(-32'sd5, 32'sd7, 32'sd7, 32'sd7);             // backward
  endtask

  // Gravity rotated by unit and unnormalized quaternions at full gravity level.
  task automatic test_gravity_orientation();
    sample_t s;
    logic signed [15:0] quats[6][4];
    quats = '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
              '{16'sd0, 16'sd16384, 16'sd0, 16'sd0},
              '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192},
              '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384},
              '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384},
              '{16'sd0, 16'sd0, -16'sd16384, 16'sd16384}};
    program_settings(1'b1, 1'b1, 21'h1f_ffff, 21'd65536, 21'd0, DAMPING_RST,
                     21'(MAX_STEP_RST));
    foreach (quats[i]) begin
      stim_stamp = stim_stamp + 32'd13107;
      s = build_sample(stim_stamp);
      s.accel_x = 32'sd1000;
      s.accel_y = -32'sd1000;
      s.accel_z = 32'sd642908;
      {s.quat_w, s.quat_x, s.quat_y, s.quat_z} =
        {quats[i][0], quats[i][1], quats[i][2], quats[i][3]};
      send_sample(s);
    end
  endtask

  // Weight above one, zero max step, full deadband with full damping and an
  // out-of-width max step write.
  task automatic test_register_extremes();
    program_settings(1'b0, 1'b0, 21'd0, 21'h1_ffff, 21'd0, 21'd0, 21'(MAX_STEP_RST));
    send_stepped(32'd4000, 32'sd123456, -32'sd654321, 32'sh7fff_ffff);
    send_stepped(32'd4000, -32'sd99999, 32'sd1, 32'sh8000_0000);

    // zero max step: smoother moves, velocity and position hold, result still comes
    program_settings(1'b1, 1'b0, GRAV_LEVEL_RST, 21'd30000, 21'd0, DAMPING_RST, 21'd0);
    send_stepped(32'd777, 32'sd400000, 32'sd400000, 32'sd0);
    send_stepped(32'd1, -32'sd400000, 32'sd12, 32'sd642908);

    // wdata bit above max_step's width is dropped by the register
    program_settings(1'b1, 1'b1, 21'h1f_ffff, 21'd65536, 21'h1f_ffff, 21'h1f_ffff, 21'h1f_ffff);
    send_stepped(32'd900000, 32'sh7fff_ffff, 32'sd2000000, -32'sd2000000);
    send_stepped(32'd12345, 32'sd2097151, -32'sd2097152, 32'sd0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering, so the
  // output register fills and the sample input stalls. Then three more samples follow.
  task automatic test_output_backpressure();
    program_settings(1'b1, 1'b0, GRAV_LEVEL_RST, 21'd20000, 21'd500, 21'd2000, 21'd20000);
    sender_gaps_on = 1'b0;
    recv_gaps_on   = 1'b0;
    hold_request   = 400;
    repeat (12) send_stepped($urandom_range(1, 20000), rand_accel(1'b0), rand_accel(1'b0),
                             rand_accel(1'b1));
    wait_idle();
    sender_gaps_on = 1'b1;
    recv_gaps_on   = 1'b1;
    repeat (3) send_stepped($urandom_range(1, 20000), rand_accel(1'b0), rand_accel(1'b0),
                            rand_accel(1'b1));
  endtask

  // Several random setting phases; the first one drives velocity into saturation.
  task automatic test_random_settings();
    sample_t s;
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        program_settings(1'b0, 1'b0, 21'd0, 21'd65536, 21'd0, 21'd0, 21'hf_ffff);
      end else begin
        program_settings($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                         pick_value(21'h1f_ffff, GRAV_LEVEL_RST),
                         pick_value(65536, SMOOTH_WT_RST),
                         pick_value(21'h1f_ffff, DEADBAND_RST),
                         pick_value(21'h1f_ffff, DAMPING_RST),
                         pick_value(20'hf_ffff, MAX_STEP_RST));
      end
      case (p % 4)
        0:       {sender_gaps_on, recv_gaps_on} = 2'b11;
        1:       {sender_gaps_on, recv_gaps_on} = 2'b00;
        2:       {sender_gaps_on, recv_gaps_on} = 2'b10;
        default: {sender_gaps_on, recv_gaps_on} = 2'b01;
      endcase
      for (int n = 0; n < 75; n++) begin
        // the phase opens with an arbitrary jump of the time base
        stim_stamp = stim_stamp + ((n == 0) ? $urandom : rand_step());
        s = build_sample(stim_stamp);
        send_sample(s);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    sample_if.valid  = 1'b0;
    sample_if.data   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    result_if.ready  = 1'b0;
    hold_request     = 0;
    hold_left        = 0;
    stall_left       = 0;
    sender_gaps_on   = 1'b0;
    recv_gaps_on     = 1'b0;
    cycle_count      = 0;
    errors           = 0;
    samples_sent     = 0;
    results_checked  = 0;
    reg_writes       = 0;
    setting_phases   = 0;
    reset_predictor();
    repeat (8) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_directed_basics();
    test_gravity_orientation();
    test_register_extremes();
    test_output_backpressure();
    test_random_settings();

    // drain, then give a trailing no-result sample time to retire
    sample_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("Run covered %0d samples and %0d checked results over %0d setting phases",
             samples_sent, results_checked, setting_phases);
    $display("(%0d register writes, %0d failures, %0d cycles)",
             reg_writes, errors, cycle_count);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== imu_dead_reckoning_integrator_unit.f =====
+incdir+rtl
rtl/idr_pkg.sv
rtl/idr_stream_if.sv
rtl/imu_dead_reckoning_integrator_unit.sv
dv/tb.sv
